>>> design/string_escape_decoder_top_assert.svh
// ----------------------------------------------------------------------------
// String escape decoder assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef STRING_ESCAPE_DECODER_TOP_ASSERT_SVH
`define STRING_ESCAPE_DECODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define ESD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("string escape decoder check failed");
// Next-cycle implication, checked outside reset.
`define ESD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("string escape decoder check failed");
`else
`define ESD_ASSERT_NOW(label, clk, rst, ante, cons)
`define ESD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> design/esd_pkg.sv
// ----------------------------------------------------------------------------
// String escape decoder package
// Shared widths, character codes, decode types and classification helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package esd_pkg;

  // Width of the character field and of the digit accumulator.
  localparam int CODE_W    = 16;
  localparam int CHAR_BITS = 16;

  // Queue between the front and the back; a power of two.
  localparam int Q_DEPTH = 4;
  localparam int PTR_W   = $clog2(Q_DEPTH);
  localparam int CNT_W   = $clog2(Q_DEPTH + 1);

  // Character codes used by the decoder.
  localparam logic [CODE_W-1:0] CH_BSLASH = CODE_W'(8'h5C);
  localparam logic [CODE_W-1:0] CH_X      = CODE_W'(8'h78);
  localparam logic [CODE_W-1:0] CH_0      = CODE_W'(8'h30);
  localparam logic [CODE_W-1:0] CH_1      = CODE_W'(8'h31);
  localparam logic [CODE_W-1:0] CH_7      = CODE_W'(8'h37);
  localparam logic [CODE_W-1:0] CH_9      = CODE_W'(8'h39);
  localparam logic [CODE_W-1:0] CH_LA     = CODE_W'(8'h61);
  localparam logic [CODE_W-1:0] CH_LF     = CODE_W'(8'h66);
  localparam logic [CODE_W-1:0] CH_UA     = CODE_W'(8'h41);
  localparam logic [CODE_W-1:0] CH_UF     = CODE_W'(8'h46);

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_CHAR    = 2'd0,
    KIND_END     = 2'd1,
    KIND_UNTERM  = 2'd2,
    KIND_UNKNOWN = 2'd3
  } esd_kind_t;

  // Decoder modes.
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_OCT    = 3'd2,
    MODE_HEX    = 3'd3,
    MODE_SKIP   = 3'd4
  } esd_mode_t;

  // One classified input transaction as it travels through the queue.
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              end_mark;
    logic              is_bslash;
    logic              is_x;
    logic              simple_hit;
    logic [6:0]        simple_val;
    logic              oct_hit;
    logic              oct_start;
    logic              hex_hit;
    logic [3:0]        digit;
  } esd_item_t;

  // Handshake between the queue head and the back end.
  typedef struct packed {
    logic      valid;
    esd_item_t item;
  } esd_head_t;

  // Simple escape lookup: hit flag in the top bit, character below it.
  function automatic logic [7:0] simple_lookup(input logic [CODE_W-1:0] c);
    logic [7:0] r;
    r = 8'h00;
    if (c[CODE_W-1:8] == '0) begin
      case (c[7:0])
        8'h6E:   r = {1'b1, 7'd10};
        8'h74:   r = {1'b1, 7'd9};
        8'h72:   r = {1'b1, 7'd13};
        8'h30:   r = {1'b1, 7'd0};
        8'h76:   r = {1'b1, 7'd11};
        8'h61:   r = {1'b1, 7'd7};
        8'h62:   r = {1'b1, 7'd8};
        8'h66:   r = {1'b1, 7'd12};
        8'h27:   r = {1'b1, 7'd39};
        8'h22:   r = {1'b1, 7'd34};
        8'h5C:   r = {1'b1, 7'd92};
        default: r = 8'h00;
      endcase
    end
    return r;
  endfunction

  // Hex digit value: hit flag in the top bit, value below it.
  function automatic logic [4:0] hex_lookup(input logic [CODE_W-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CH_0 && c <= CH_9) begin
      r = {1'b1, 4'(c - CH_0)};
    end else if (c >= CH_LA && c <= CH_LF) begin
      r = {1'b1, 4'(c - CH_LA + CODE_W'(10))};
    end else if (c >= CH_UA && c <= CH_UF) begin
      r = {1'b1, 4'(c - CH_UA + CODE_W'(10))};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/esd_front.sv
// ----------------------------------------------------------------------------
// String escape decoder front end
// Accepts input transactions and classifies each character for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module esd_front (
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [esd_pkg::CODE_W-1:0] char_code,
  input  wire logic                     end_mark,
  input  wire logic                     q_full,
  output logic                          push,
  output esd_pkg::esd_item_t            push_item
);

  logic [7:0] simple_res;
  logic [4:0] hex_res;

  // Accept whenever the queue has room.
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // Table lookups on the raw character.
  assign simple_res = esd_pkg::simple_lookup(char_code);
  assign hex_res    = esd_pkg::hex_lookup(char_code);

  // Build the classified record.
  always_comb begin
    push_item            = '0;
    push_item.code       = char_code;
    push_item.end_mark   = end_mark;
    push_item.is_bslash  = (char_code == esd_pkg::CH_BSLASH);
    push_item.is_x       = (char_code == esd_pkg::CH_X);
    push_item.simple_hit = simple_res[7];
    push_item.simple_val = simple_res[6:0];
    push_item.oct_hit    = (char_code >= esd_pkg::CH_0) && (char_code <= esd_pkg::CH_7);
    push_item.oct_start  = (char_code >= esd_pkg::CH_1) && (char_code <= esd_pkg::CH_7);
    push_item.hex_hit    = hex_res[4];
    push_item.digit      = hex_res[3:0];
  end

endmodule

`default_nettype wire

>>> design/esd_fifo.sv
// ----------------------------------------------------------------------------
// String escape decoder queue
// Short first-in first-out buffer between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module esd_fifo (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  input  wire esd_pkg::esd_item_t       push_item,
  output logic                          full,
  input  wire logic                     pop,
  output esd_pkg::esd_head_t            head,
  output logic [esd_pkg::CNT_W-1:0]     count
);

  esd_pkg::esd_item_t             mem [esd_pkg::Q_DEPTH];
  logic [esd_pkg::PTR_W-1:0]      wr_ptr;
  logic [esd_pkg::PTR_W-1:0]      rd_ptr;

  assign full       = (count == esd_pkg::CNT_W'(esd_pkg::Q_DEPTH));
  assign head.valid = (count != '0);
  assign head.item  = mem[rd_ptr];

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

>>> design/esd_back.sv
// ----------------------------------------------------------------------------
// String escape decoder back end
// Runs the escape state machine on classified characters and drives results.
// ----------------------------------------------------------------------------
`default_nettype none

module esd_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire esd_pkg::esd_head_t         head,
  output logic                            pop,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [esd_pkg::CODE_W-1:0]      out_char,
  output logic [1:0]                      kind,
  output logic                            last_of_run
);

  esd_pkg::esd_mode_t               mode;
  esd_pkg::esd_mode_t               mode_next;
  logic [esd_pkg::CHAR_BITS-1:0]    escape_value;
  logic [esd_pkg::CHAR_BITS-1:0]    escape_value_next;
  esd_pkg::esd_item_t               it;

  logic                             res_has;
  logic [esd_pkg::CODE_W-1:0]       res_char;
  esd_pkg::esd_kind_t               res_kind;
  logic                             res_last;
  logic                             do_pop;
  logic                             out_free;
  logic                             step;

  assign it       = head.item;
  assign out_free = !out_valid || out_ready;
  // A transaction without a result never waits for the output register.
  assign step     = head.valid && (!res_has || out_free);
  assign pop      = step && do_pop;

  // Next state and result for the transaction at the queue head.
  always_comb begin
    mode_next         = mode;
    escape_value_next = escape_value;
    res_has           = 1'b0;
    res_char          = '0;
    res_kind          = esd_pkg::KIND_CHAR;
    res_last          = 1'b1;
    do_pop            = 1'b1;
    case (mode)
      esd_pkg::MODE_NORMAL: begin
        if (it.end_mark) begin
          res_has           = 1'b1;
          res_kind          = esd_pkg::KIND_END;
          escape_value_next = '0;
        end else if (it.is_bslash) begin
          mode_next = esd_pkg::MODE_ESC;
        end else begin
          res_has  = 1'b1;
          res_char = it.code;
        end
      end
      esd_pkg::MODE_ESC: begin
        if (it.end_mark) begin
          res_has           = 1'b1;
          res_kind          = esd_pkg::KIND_UNTERM;
          mode_next         = esd_pkg::MODE_NORMAL;
          escape_value_next = '0;
        end else if (it.simple_hit) begin
          res_has   = 1'b1;
          res_char  = esd_pkg::CODE_W'(it.simple_val);
          mode_next = esd_pkg::MODE_NORMAL;
        end else if (it.is_x) begin
          escape_value_next = '0;
          mode_next         = esd_pkg::MODE_HEX;
        end else if (it.oct_start) begin
          escape_value_next = esd_pkg::CHAR_BITS'(it.digit[2:0]);
          mode_next         = esd_pkg::MODE_OCT;
        end else begin
          res_has           = 1'b1;
          res_kind          = esd_pkg::KIND_UNKNOWN;
          mode_next         = esd_pkg::MODE_SKIP;
          escape_value_next = '0;
        end
      end
      esd_pkg::MODE_OCT, esd_pkg::MODE_HEX: begin
        if (!it.end_mark && mode == esd_pkg::MODE_OCT && it.oct_hit) begin
          escape_value_next = {escape_value[esd_pkg::CHAR_BITS-4:0], it.digit[2:0]};
        end else if (!it.end_mark && mode == esd_pkg::MODE_HEX && it.hex_hit) begin
          escape_value_next = {escape_value[esd_pkg::CHAR_BITS-5:0], it.digit};
        end else begin
          // Number ends: emit the value, then the item is seen again in
          // normal mode unless it is a backslash, which gives no result.
          res_has           = 1'b1;
          res_char          = esd_pkg::CODE_W'(escape_value);
          escape_value_next = '0;
          if (!it.end_mark && it.is_bslash) begin
            mode_next = esd_pkg::MODE_ESC;
          end else begin
            mode_next = esd_pkg::MODE_NORMAL;
            res_last  = 1'b0;
            do_pop    = 1'b0;
          end
        end
      end
      esd_pkg::MODE_SKIP: begin
        if (it.end_mark) begin
          mode_next         = esd_pkg::MODE_NORMAL;
          escape_value_next = '0;
        end
      end
      default: begin
        mode_next         = esd_pkg::MODE_NORMAL;
        escape_value_next = '0;
      end
    endcase
  end

  // Decoder state and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= esd_pkg::MODE_NORMAL;
      escape_value <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (step) begin
        mode         <= mode_next;
        escape_value <= escape_value_next;
      end
      if (out_free) begin
        out_valid <= step && res_has;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (out_free && step && res_has) begin
      out_char    <= res_char;
      kind        <= res_kind;
      last_of_run <= res_last;
    end
  end

endmodule

`default_nettype wire

>>> design/string_escape_decoder_top.sv
// ----------------------------------------------------------------------------
// String escape decoder top level
// Unescapes C-style string literal bodies, one character per transaction.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake            Payload
//   input     in         in_valid / in_ready  char_code, end_mark
//   output    out        out_valid/out_ready  out_char, kind, last_of_run
//
// One input transaction is taken per cycle while the four-entry queue has room.
// The back end retires one transaction per cycle unless its result is stalled;
// one that ends a numeric escape and yields a second result is decoded again.
// The output register frees the back end whenever its result is taken.
// Synchronous reset clears the queue, the decoder mode and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

`include "string_escape_decoder_top_assert.svh"

module string_escape_decoder_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [esd_pkg::CODE_W-1:0] char_code,
  input  wire logic                       end_mark,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [esd_pkg::CODE_W-1:0]      out_char,
  output logic [1:0]                      kind,
  output logic                            last_of_run
);

  logic                          q_full;
  logic                          push;
  esd_pkg::esd_item_t            push_item;
  logic                          pop;
  esd_pkg::esd_head_t            head;
  logic [esd_pkg::CNT_W-1:0]     q_count;

  // Classification.
  esd_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_code (char_code),
    .end_mark  (end_mark),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // Decoupling queue.
  esd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .count     (q_count)
  );

  // Escape state machine and output register.
  esd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .kind        (kind),
    .last_of_run (last_of_run)
  );

  // Queue occupancy stays within its depth.
  `ESD_ASSERT_NOW(a_q_bound, clk, rst, 1'b1, q_count <= esd_pkg::CNT_W'(esd_pkg::Q_DEPTH))
  // Non-character results carry a zero character field.
  `ESD_ASSERT_NOW(a_zero_char, clk, rst, out_valid && kind != esd_pkg::KIND_CHAR, out_char == '0)
  // The second result of a two-result run follows right after the first.
  `ESD_ASSERT_NEXT(a_run_cont, clk, rst, out_valid && out_ready && !last_of_run, out_valid)

endmodule

`default_nettype wire

>>> dv/string_escape_decoder_top_tb.sv
// ----------------------------------------------------------------------------
// String escape decoder testbench
// Feeds string literal bodies, character by character with end marks, into
// the decoder and checks every unescaped result against an in-bench decode
// of the same stream. Directed cases cover the character extremes, the
// escape forms and their corner cases. Random literals follow, under phases
// of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module string_escape_decoder_top_tb;
  import esd_pkg::*;

  // One unescaped result as the decoder should produce it.
  typedef struct {
    logic [CODE_W-1:0] ch;
    esd_kind_t         kind;
    logic              last_flag;
  } decoded_t;

  // Codes of the simple escape letters, used to build stimulus.
  localparam logic [CODE_W-1:0] SIMPLE_LEADS [11] = '{
    16'h006E, 16'h0074, 16'h0072, 16'h0030, 16'h0076, 16'h0061,
    16'h0062, 16'h0066, 16'h0027, 16'h0022, 16'h005C
  };

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [CODE_W-1:0] char_code;
  logic              end_mark;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CODE_W-1:0] out_char;
  logic [1:0]        kind;
  logic              last_of_run;

  // Decode state of the in-bench model.
  esd_mode_t          esc_mode = MODE_NORMAL;
  logic [CHAR_BITS-1:0] esc_acc = '0;

  decoded_t pending[$];
  decoded_t head_res;
  int       fail_count   = 0;
  int       live_items   = 0;
  int       tx_idle_pct  = 0;
  int       rx_stall_pct = 0;

  string_escape_decoder_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .char_code   (char_code),
    .end_mark    (end_mark),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .kind        (kind),
    .last_of_run (last_of_run)
  );

  // Clock with a period of ten units.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Simple escape lookup: hit flag on top, character code below.
  function automatic logic [CODE_W:0] simple_escape_value(input logic [CODE_W-1:0] c);
    case (c)
      16'h006E: return {1'b1, 16'd10};  // n
      16'h0074: return {1'b1, 16'd9};   // t
      16'h0072: return {1'b1, 16'd13};  // r
      16'h0030: return {1'b1, 16'd0};   // 0
      16'h0076: return {1'b1, 16'd11};  // v
      16'h0061: return {1'b1, 16'd7};   // a
      16'h0062: return {1'b1, 16'd8};   // b
      16'h0066: return {1'b1, 16'd12};  // f
      16'h0027: return {1'b1, 16'd39};  // single quote
      16'h0022: return {1'b1, 16'd34};  // double quote
      16'h005C: return {1'b1, 16'd92};  // backslash
      default:  return '0;
    endcase
  endfunction

  // Digit value in the given radix, or -1 when the code is not a digit.
  function automatic int digit_value(input logic [CODE_W-1:0] c, input bit octal);
    if (octal) return (c >= CH_0 && c <= CH_7) ? int'(c - CH_0) : -1;
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
    if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    return -1;
  endfunction

  function automatic bit starts_escape(input logic [CODE_W-1:0] c);
    logic [CODE_W:0] simple;
    simple = simple_escape_value(c);
    return simple[CODE_W] || c == CH_X || (c >= CH_1 && c <= CH_7);
  endfunction

  // Builds one expected result; the last flag is set once the run is known.
  function automatic decoded_t make_res(input logic [CODE_W-1:0] ch, input esd_kind_t k);
    decoded_t r;
    r.ch        = ch;
    r.kind      = k;
    r.last_flag = 1'b0;
    return r;
  endfunction

  // Advances the decode state by one accepted transaction and queues the
  // results it gives.
  task automatic decode_step(input logic [CODE_W-1:0] c, input logic e);
    decoded_t          batch[$];
    logic [CODE_W:0]   simple;
    logic              as_normal;
    int                d;
    as_normal = 1'b0;
    case (esc_mode)
      MODE_NORMAL: as_normal = 1'b1;
      MODE_ESC: begin
        simple = simple_escape_value(c);
        if (e) begin
          batch.insert(batch.size(), make_res('0, KIND_UNTERM));
          esc_mode = MODE_NORMAL;
          esc_acc  = '0;
        end else if (simple[CODE_W]) begin
          batch.insert(batch.size(), make_res(simple[CODE_W-1:0], KIND_CHAR));
          esc_mode = MODE_NORMAL;
        end else if (c == CH_X) begin
          esc_acc  = '0;
          esc_mode = MODE_HEX;
        end else if (c >= CH_1 && c <= CH_7) begin
          esc_acc  = CHAR_BITS'(c - CH_0);
          esc_mode = MODE_OCT;
        end else begin
          batch.insert(batch.size(), make_res('0, KIND_UNKNOWN));
          esc_mode = MODE_SKIP;
          esc_acc  = '0;
        end
      end
      MODE_OCT, MODE_HEX: begin
        d = e ? -1 : digit_value(c, esc_mode == MODE_OCT);
        if (d >= 0) begin
          esc_acc = CHAR_BITS'(32'(esc_acc) * (esc_mode == MODE_OCT ? 8 : 16) + d);
        end else begin
          // The number ends here; the terminating transaction is then decoded
          // as an ordinary one.
          batch.insert(batch.size(), make_res(CODE_W'(esc_acc), KIND_CHAR));
          esc_acc   = '0;
          esc_mode  = MODE_NORMAL;
          as_normal = 1'b1;
        end
      end
      default: begin
        if (e) begin
          esc_mode = MODE_NORMAL;
          esc_acc  = '0;
        end
      end
    endcase
    if (as_normal) begin
      if (e) begin
        batch.insert(batch.size(), make_res('0, KIND_END));
        esc_acc = '0;
      end else if (c == CH_BSLASH) begin
        esc_mode = MODE_ESC;
      end else begin
        batch.insert(batch.size(), make_res(c, KIND_CHAR));
      end
    end
    if (batch.size() > 0) batch[batch.size()-1].last_flag = 1'b1;
    foreach (batch[i]) pending.insert(pending.size(), batch[i]);
  endtask

  // Offers one transaction, with idle cycles first, and waits for acceptance.
  task automatic send_item(input logic [CODE_W-1:0] c, input logic e);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    end_mark  <= e;
    do @(posedge clk); while (!(in_valid && in_ready));
    live_items++;
    decode_step(c, e);
  endtask

  // Holds the sender off until every queued result has come out.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending.size() != 0);
  endtask

  // Result checker: each taken result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        $error("unexpected result: out_char %h kind %0d last_of_run %b",
               out_char, kind, last_of_run);
        fail_count++;
      end else begin
        head_res = pending.pop_front();
        if (out_char !== head_res.ch) begin
          $error("out_char: expected %h, got %h", head_res.ch, out_char);
          fail_count++;
        end
        if (kind !== head_res.kind) begin
          $error("kind: expected %0d, got %0d", head_res.kind, kind);
          fail_count++;
        end
        if (last_of_run !== head_res.last_flag) begin
          $error("last_of_run: expected %b, got %b", head_res.last_flag, last_of_run);
          fail_count++;
        end
      end
    end
  end

  // Stimulus helpers.
  function automatic logic [CODE_W-1:0] random_plain();
    logic [CODE_W-1:0] c;
    if ($urandom_range(4) == 0) c = CODE_W'($urandom());
    else c = CODE_W'($urandom_range(32, 126));
    if (c == CH_BSLASH) c = c + 1'b1;
    return c;
  endfunction

  function automatic logic [CODE_W-1:0] random_bad_lead();
    logic [CODE_W-1:0] c;
    do begin
      case ($urandom_range(3))
        0:       c = CH_9 - CODE_W'($urandom_range(1));
        1:       c = CODE_W'($urandom_range(32, 126));
        default: c = CODE_W'($urandom());
      endcase
    end while (starts_escape(c));
    return c;
  endfunction

  function automatic logic [CODE_W-1:0] hex_char(input int d);
    if (d < 10) return CH_0 + CODE_W'(d);
    return ($urandom_range(1) ? CH_LA : CH_UA) + CODE_W'(d - 10);
  endfunction

  task automatic send_hex_escape();
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_X, 1'b0);
    repeat ($urandom_range(0, 6)) send_item(hex_char($urandom_range(15)), 1'b0);
  endtask

  task automatic send_oct_escape();
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_1 + CODE_W'($urandom_range(6)), 1'b0);
    repeat ($urandom_range(0, 7)) send_item(CH_0 + CODE_W'($urandom_range(7)), 1'b0);
  endtask

  // One random literal: a run of tokens closed by an end mark.
  task automatic send_random_literal();
    int sel;
    repeat ($urandom_range(1, 8)) begin
      sel = $urandom_range(99);
      if (sel < 35) begin
        send_item(random_plain(), 1'b0);
      end else if (sel < 55) begin
        send_item(CH_BSLASH, 1'b0);
        send_item(SIMPLE_LEADS[$urandom_range(10)], 1'b0);
      end else if (sel < 70) begin
        send_hex_escape();
      end else if (sel < 82) begin
        send_oct_escape();
      end else if (sel < 90) begin
        // Bad escape; what follows is skipped up to the end mark.
        send_item(CH_BSLASH, 1'b0);
        send_item(random_bad_lead(), 1'b0);
        repeat ($urandom_range(0, 3)) send_item(CODE_W'($urandom()), 1'b0);
      end else begin
        send_item(CODE_W'($urandom()), ($urandom_range(3) == 0));
      end
    end
    if ($urandom_range(9) == 0) send_item(CH_BSLASH, 1'b0);
    send_item(CODE_W'($urandom()), 1'b1);
  endtask

  // Directed tests.
  task automatic test_plain_extremes();
    send_item(16'h0000, 1'b0);
    send_item(16'hFFFF, 1'b0);
    send_item(CH_UA, 1'b0);
    send_item(16'hFFFF, 1'b1);
  endtask

  task automatic test_simple_escapes();
    send_item(CH_BSLASH, 1'b0);
    send_item(SIMPLE_LEADS[0], 1'b0);
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_BSLASH, 1'b0);
    send_item(SIMPLE_LEADS[9], 1'b0);
    send_item(16'h0000, 1'b1);
  endtask

  // An octal number closed by a plain character gives two results.
  task automatic test_number_end();
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_1, 1'b0);
    send_item(CH_7, 1'b0);
    send_item(16'h007A, 1'b0);
    send_item(16'h0000, 1'b1);
  endtask

  // A hex escape with no digits, closed by the end mark.
  task automatic test_empty_hex();
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_X, 1'b0);
    send_item(16'h0000, 1'b1);
  endtask

  // Eight is no octal digit; the rest of the literal is skipped.
  task automatic test_bad_escape();
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_9 - 1'b1, 1'b0);
    send_item(16'h0071, 1'b0);
    send_item(16'h0000, 1'b1);
  endtask

  task automatic test_unterminated();
    send_item(CH_BSLASH, 1'b0);
    send_item(16'h0000, 1'b1);
  endtask

  // A wide code after a backslash is an unknown escape.
  task automatic test_wide_after_backslash();
    send_item(CH_BSLASH, 1'b0);
    send_item(16'h0130, 1'b0);
    send_item(16'h5555, 1'b1);
  endtask

  task automatic test_random_traffic(input int n, input int tx_pct, input int rx_pct);
    int target;
    target       = live_items + n;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    while (live_items < target) send_random_literal();
    wait_for_results();
  endtask

  // Main sequence.
  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    char_code = '0;
    end_mark  = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_plain_extremes();
    test_simple_escapes();
    test_number_end();
    test_empty_hex();
    test_bad_escape();
    test_unterminated();
    test_wide_after_backslash();

    test_random_traffic(300, 0, 0);
    test_random_traffic(250, 75, 0);
    test_random_traffic(250, 0, 75);
    test_random_traffic(250, 26, 26);
    test_random_traffic(150, 0, 0);

    // Let any late or surplus result show itself before the verdict.
    wait_for_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

>>> string_escape_decoder_top.f
+incdir+design
design/esd_pkg.sv
design/esd_front.sv
design/esd_fifo.sv
design/esd_back.sv
design/string_escape_decoder_top.sv
dv/string_escape_decoder_top_tb.sv
